// ===== rtl/job_shop_transport_makespan_eval_unit_macros.svh =====
// assertion macros for the job shop transport makespan evaluator
`ifndef JOB_SHOP_TRANSPORT_MAKESPAN_EVAL_UNIT_MACROS_SVH
`define JOB_SHOP_TRANSPORT_MAKESPAN_EVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define JSTME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define JSTME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSTME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define JSTME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/jstme_pkg.sv =====
// shared types, field widths and default sizes of the makespan evaluator
package jstme_pkg;

  // default sizing
  localparam int DEF_MAX_JOBS     = 16;
  localparam int DEF_MAX_OPS      = 16;
  localparam int DEF_MAX_ALTS     = 4;
  localparam int DEF_MAX_MACHINES = 16;
  localparam int DEF_MAX_ROBOTS   = 4;
  localparam int DEF_TIME_WIDTH   = 32;

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int JOB_W   = 4;
  localparam int OP_W    = 4;
  localparam int ALT_W   = 2;
  localparam int CNT_W   = 3;
  localparam int MACH_W  = 4;
  localparam int VAL_W   = 16;
  localparam int ROBOT_W = 2;
  localparam int OUT_W   = 32;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_TRAVEL = 2'd0,
    KIND_LOAD_ALT    = 2'd1,
    KIND_CLEAR       = 2'd2,
    KIND_SCHEDULE    = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ROUTE,
    ST_MOVE,
    ST_FIN
  } state_t;

  // index width for a store of the given depth, never below one bit
  function automatic int idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== rtl/job_shop_transport_makespan_eval_unit.sv =====
// Flexible job-shop makespan evaluator with transport robots.
// Input channel in_*: one item per transfer (load travel distance, load
// alternative, clear schedule, schedule operation). Result channel out_*:
// exactly one result per item, in order: running makespan, finish time of
// the scheduled operation (0 otherwise) and an error flag.
// A load or clear item goes from the input transfer straight to the
// finish step, whose result is registered in the output register; a
// schedule item first passes three chained registered ram reads (job
// entry, then alternative, count and robot-to-job travel, then
// job-to-machine travel and machine time) and the saturating max-and-add
// update, and goes to the finish step early when a check flags an error.
// One item is in work at a time; the next is taken once the previous
// result sits in the output register.
// Reset (rst_n low, synchronous) clears job and machine state through
// valid bits and robot state and the makespan directly, with no clearing
// pass; the travel and alternative tables are undefined until loaded.
// Output stall: a finished item waits in the finish step until the output
// register is free, and in_ready stays low meanwhile.
`include "job_shop_transport_makespan_eval_unit_macros.svh"

module job_shop_transport_makespan_eval_unit #(
  parameter int MAX_JOBS     = jstme_pkg::DEF_MAX_JOBS,
  parameter int MAX_OPS      = jstme_pkg::DEF_MAX_OPS,
  parameter int MAX_ALTS     = jstme_pkg::DEF_MAX_ALTS,
  parameter int MAX_MACHINES = jstme_pkg::DEF_MAX_MACHINES,
  parameter int MAX_ROBOTS   = jstme_pkg::DEF_MAX_ROBOTS,
  parameter int TIME_WIDTH   = jstme_pkg::DEF_TIME_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jstme_pkg::KIND_W-1:0] in_kind,
  input  logic [jstme_pkg::JOB_W-1:0]  in_job,
  input  logic [jstme_pkg::OP_W-1:0]   in_op_index,
  input  logic [jstme_pkg::ALT_W-1:0]  in_alt,
  input  logic [jstme_pkg::CNT_W-1:0]  in_alt_count,
  input  logic [jstme_pkg::MACH_W-1:0] in_from_machine,
  input  logic [jstme_pkg::MACH_W-1:0] in_to_machine,
  input  logic [jstme_pkg::VAL_W-1:0]  in_value,
  input  logic [jstme_pkg::ROBOT_W-1:0] in_robot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [jstme_pkg::OUT_W-1:0]  out_makespan,
  output logic [jstme_pkg::OUT_W-1:0]  out_finish_time,
  output logic                         out_error
);

  import jstme_pkg::*;

  localparam int TW  = TIME_WIDTH;
  localparam int MW  = idx_w(MAX_MACHINES);
  localparam int JW  = idx_w(MAX_JOBS);
  localparam int RW  = idx_w(MAX_ROBOTS);
  localparam int CW  = $clog2(MAX_OPS + 1);
  localparam int JOD = MAX_JOBS * MAX_OPS;
  localparam int JOW = idx_w(JOD);
  localparam int ALD = JOD * MAX_ALTS;
  localparam int ALW = idx_w(ALD);
  localparam int TRD = MAX_MACHINES * MAX_MACHINES;
  localparam int TRW = idx_w(TRD);
  localparam int JEW = CW + MW + TW;
  localparam int AEW = MW + VAL_W;
  localparam logic [TW-1:0] TIME_MAX = '1;

  // saturating time plus 16-bit duration
  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [VAL_W-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + (TW+1)'(b);
    return s[TW] ? TIME_MAX : s[TW-1:0];
  endfunction

  // control state
  state_t              state_r, state_nxt;
  logic                out_valid_r;
  logic [MAX_JOBS-1:0] job_vld_r;
  logic [MAX_MACHINES-1:0] mach_vld_r;
  logic [TW-1:0]       robot_time_r  [MAX_ROBOTS];
  logic [MW-1:0]       robot_place_r [MAX_ROBOTS];
  logic [TW-1:0]       ms_r;

  // item payload
  kind_t               kind_r;
  logic [JOB_W-1:0]    job_r;
  logic [OP_W-1:0]     op_r;
  logic [ALT_W-1:0]    alt_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MACH_W-1:0]   from_r;
  logic [MACH_W-1:0]   to_r;
  logic [VAL_W-1:0]    val_r;
  logic [ROBOT_W-1:0]  robot_r;
  logic                err_r;
  logic                job_rd_vld_r;
  logic                mach_rd_vld_r;
  logic [TW-1:0]       reach_r;
  logic [TW-1:0]       arrive_r;
  logic [TW-1:0]       out_ms_r;
  logic [TW-1:0]       out_fin_r;
  logic                out_err_r;

  // handshake and decode
  logic                in_xfer;
  logic                in_bad;
  logic                out_free;
  logic                fin_go;
  logic                err_set;
  logic                op_bad;
  logic                alt_bad;

  // ram ports
  logic                job_re, job_we;
  logic [JW-1:0]       job_raddr;
  logic [JEW-1:0]      job_wdata, job_rdata, job_ent;
  logic                cnt_re, cnt_we;
  logic [JOW-1:0]      cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0]    cnt_rdata;
  logic                alt_re, alt_we;
  logic [ALW-1:0]      alt_raddr, alt_waddr;
  logic [AEW-1:0]      alt_rdata;
  logic                trav_re, trav_we;
  logic [TRW-1:0]      trav_raddr, trav_waddr;
  logic [VAL_W-1:0]    trav_rdata;
  logic                mach_re, mach_we;
  logic [TW-1:0]       mach_rdata, mach_time;

  // working values
  logic [JW-1:0]       job_idx;
  logic [RW-1:0]       robot_idx;
  logic [CW-1:0]       nop;
  logic [MW-1:0]       jp, rp, m_sel;
  logic [TW-1:0]       ready_time, depart, base_time, mt, ms_nxt;
  logic [VAL_W-1:0]    p_time;
  logic [JOW-1:0]      sched_jo, load_jo;
  logic                same_place;
  logic                sched_wr, clear_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign job_idx   = JW'(job_r);
  assign robot_idx = RW'(robot_r);

  // range checks known at the input transfer
  always_comb begin
    unique case (kind_t'(in_kind))
      KIND_LOAD_TRAVEL: in_bad = (int'(in_from_machine) >= MAX_MACHINES) ||
                                 (int'(in_to_machine) >= MAX_MACHINES);
      KIND_LOAD_ALT:    in_bad = (int'(in_job) >= MAX_JOBS) ||
                                 (int'(in_op_index) >= MAX_OPS) ||
                                 (int'(in_alt) >= MAX_ALTS) ||
                                 (int'(in_from_machine) >= MAX_MACHINES);
      KIND_CLEAR:       in_bad = 1'b0;
      KIND_SCHEDULE:    in_bad = (int'(in_job) >= MAX_JOBS) ||
                                 (int'(in_robot) >= MAX_ROBOTS) ||
                                 (int'(in_alt) >= MAX_ALTS);
      default:          in_bad = 1'b1;
    endcase
  end

  // job entry fields, an entry not written since clear reads as zero
  assign job_ent    = job_rd_vld_r ? job_rdata : '0;
  assign nop        = job_ent[JEW-1 -: CW];
  assign jp         = job_ent[TW +: MW];
  assign ready_time = job_ent[TW-1:0];
  assign rp         = robot_place_r[robot_idx];
  assign op_bad     = (int'(nop) >= MAX_OPS);

  // table addresses
  assign sched_jo  = JOW'(job_idx) * JOW'(MAX_OPS) + JOW'(nop);
  assign load_jo   = JOW'(job_idx) * JOW'(MAX_OPS) + JOW'(op_r);
  assign cnt_raddr = sched_jo;
  assign alt_raddr = ALW'(sched_jo) * ALW'(MAX_ALTS) + ALW'(alt_r);
  assign cnt_waddr = load_jo;
  assign alt_waddr = ALW'(load_jo) * ALW'(MAX_ALTS) + ALW'(alt_r);
  assign trav_waddr = TRW'(MW'(from_r)) * TRW'(MAX_MACHINES) + TRW'(MW'(to_r));
  assign job_raddr = JW'(in_job);

  // chosen alternative
  assign m_sel   = alt_rdata[AEW-1 -: MW];
  assign p_time  = alt_rdata[VAL_W-1:0];
  assign alt_bad = ({1'b0, alt_r} >= cnt_rdata);

  // transport timing and machine update
  assign depart     = (ready_time > reach_r) ? ready_time : reach_r;
  assign mach_time  = mach_rd_vld_r ? mach_rdata : '0;
  assign same_place = (m_sel == jp);
  assign base_time  = same_place ? mach_time :
                      ((mach_time > arrive_r) ? mach_time : arrive_r);
  assign mt         = sat_add(base_time, p_time);

  // commits of the finishing item
  assign sched_wr = fin_go && (kind_r == KIND_SCHEDULE) && !err_r;
  assign clear_go = fin_go && (kind_r == KIND_CLEAR);
  assign trav_we  = fin_go && (kind_r == KIND_LOAD_TRAVEL) && !err_r;
  assign alt_we   = fin_go && (kind_r == KIND_LOAD_ALT) && !err_r;
  assign cnt_we   = alt_we;
  assign mach_we  = sched_wr;
  assign job_we   = sched_wr;
  assign job_wdata = {nop + CW'(1), m_sel, mt};
  assign ms_nxt   = clear_go ? '0 :
                    (sched_wr && (mt > ms_r)) ? mt : ms_r;

  // sequencer: next state and ram read controls
  always_comb begin
    state_nxt  = state_r;
    job_re     = 1'b0;
    cnt_re     = 1'b0;
    alt_re     = 1'b0;
    trav_re    = 1'b0;
    mach_re    = 1'b0;
    trav_raddr = TRW'(rp) * TRW'(MAX_MACHINES) + TRW'(jp);
    fin_go     = 1'b0;
    err_set    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          job_re    = 1'b1;
          state_nxt = ((kind_t'(in_kind) == KIND_SCHEDULE) && !in_bad) ? ST_LOOK : ST_FIN;
        end
      end
      ST_LOOK: begin
        if (op_bad) begin
          err_set   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cnt_re    = 1'b1;
          alt_re    = 1'b1;
          trav_re   = 1'b1;
          state_nxt = ST_ROUTE;
        end
      end
      ST_ROUTE: begin
        trav_raddr = TRW'(jp) * TRW'(MAX_MACHINES) + TRW'(m_sel);
        if (alt_bad) begin
          err_set   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          trav_re   = 1'b1;
          mach_re   = 1'b1;
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          fin_go    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // schedule state: valid bits, robots and makespan
  always_ff @(posedge clk) begin
    if (!rst_n || clear_go) begin
      job_vld_r  <= '0;
      mach_vld_r <= '0;
      ms_r       <= '0;
      for (int i = 0; i < MAX_ROBOTS; i++) begin
        robot_time_r[i]  <= '0;
        robot_place_r[i] <= '0;
      end
    end else begin
      ms_r <= ms_nxt;
      if (sched_wr) begin
        job_vld_r[job_idx] <= 1'b1;
        mach_vld_r[m_sel]  <= 1'b1;
        if (!same_place) begin
          robot_time_r[robot_idx]  <= arrive_r;
          robot_place_r[robot_idx] <= m_sel;
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // item payload and pipeline values
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r       <= kind_t'(in_kind);
      job_r        <= in_job;
      op_r         <= in_op_index;
      alt_r        <= in_alt;
      cnt_r        <= in_alt_count;
      from_r       <= in_from_machine;
      to_r         <= in_to_machine;
      val_r        <= in_value;
      robot_r      <= in_robot;
      err_r        <= in_bad;
      job_rd_vld_r <= job_vld_r[job_raddr];
    end else if (err_set) begin
      err_r <= 1'b1;
    end
    if (mach_re) begin
      mach_rd_vld_r <= mach_vld_r[m_sel];
    end
    if (state_r == ST_ROUTE) begin
      reach_r <= sat_add(robot_time_r[robot_idx], trav_rdata);
    end
    if (state_r == ST_MOVE) begin
      arrive_r <= sat_add(depart, trav_rdata);
    end
    if (fin_go) begin
      out_ms_r  <= ms_nxt;
      out_fin_r <= sched_wr ? mt : '0;
      out_err_r <= err_r;
    end
  end

  // job entry: done count, place, ready time
  jstme_ram #(.WIDTH(JEW), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_idx),
    .wdata (job_wdata),
    .re    (job_re),
    .raddr (job_raddr),
    .rdata (job_rdata)
  );

  // machine completion times
  jstme_ram #(.WIDTH(TW), .DEPTH(MAX_MACHINES)) u_mach_ram (
    .clk   (clk),
    .we    (mach_we),
    .waddr (m_sel),
    .wdata (mt),
    .re    (mach_re),
    .raddr (m_sel),
    .rdata (mach_rdata)
  );

  // machine-to-machine travel distances
  jstme_ram #(.WIDTH(VAL_W), .DEPTH(TRD)) u_trav_ram (
    .clk   (clk),
    .we    (trav_we),
    .waddr (trav_waddr),
    .wdata (val_r),
    .re    (trav_re),
    .raddr (trav_raddr),
    .rdata (trav_rdata)
  );

  // alternatives: machine and processing time
  jstme_ram #(.WIDTH(AEW), .DEPTH(ALD)) u_alt_ram (
    .clk   (clk),
    .we    (alt_we),
    .waddr (alt_waddr),
    .wdata ({MW'(from_r), val_r}),
    .re    (alt_re),
    .raddr (alt_raddr),
    .rdata (alt_rdata)
  );

  // alternative counts per job and operation
  jstme_ram #(.WIDTH(CNT_W), .DEPTH(JOD)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_r),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // result ports
  assign out_valid       = out_valid_r;
  assign out_makespan    = OUT_W'(64'(out_ms_r));
  assign out_finish_time = OUT_W'(64'(out_fin_r));
  assign out_error       = out_err_r;

  // checks
  `JSTME_ASSERT_NEXT(a_single_item_in_work, clk, rst_n, in_valid && in_ready, !in_ready, "second item taken while one is in work")
  `JSTME_ASSERT_IMPL(a_error_has_no_finish, clk, rst_n, out_valid && out_error, out_finish_time == '0, "flagged result carries a finish time")
  `JSTME_ASSERT_NEXT(a_finish_waits_on_stall, clk, rst_n, (state_r == ST_FIN) && out_valid_r && !out_ready, (state_r == ST_FIN) && $stable(out_ms_r), "waiting result overwritten")

endmodule

// ===== rtl/jstme_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module jstme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port, read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== verif/job_shop_transport_makespan_eval_unit_test.sv =====
// self-checking testbench for the job shop transport makespan evaluator
`timescale 1ns / 1ps

module job_shop_transport_makespan_eval_unit_test;
  import jstme_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int RANDOM_ITEMS = 460;
  localparam int TAIL_CYCLES = 20;

  // one input item, field by field
  typedef struct {
    kind_t              kind;
    logic [JOB_W-1:0]   job;
    logic [OP_W-1:0]    op_index;
    logic [ALT_W-1:0]   alt;
    logic [CNT_W-1:0]   alt_count;
    logic [MACH_W-1:0]  from_machine;
    logic [MACH_W-1:0]  to_machine;
    logic [VAL_W-1:0]   value;
    logic [ROBOT_W-1:0] robot;
  } op_item_t;

  // one result item
  typedef struct {
    logic [OUT_W-1:0] makespan;
    logic [OUT_W-1:0] finish;
    logic             err;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [JOB_W-1:0] in_job = '0;
  logic [OP_W-1:0] in_op_index = '0;
  logic [ALT_W-1:0] in_alt = '0;
  logic [CNT_W-1:0] in_alt_count = '0;
  logic [MACH_W-1:0] in_from_machine = '0;
  logic [MACH_W-1:0] in_to_machine = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic [ROBOT_W-1:0] in_robot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] out_makespan;
  logic [OUT_W-1:0] out_finish_time;
  logic out_error;

  job_shop_transport_makespan_eval_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_job          (in_job),
    .in_op_index     (in_op_index),
    .in_alt          (in_alt),
    .in_alt_count    (in_alt_count),
    .in_from_machine (in_from_machine),
    .in_to_machine   (in_to_machine),
    .in_value        (in_value),
    .in_robot        (in_robot),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_makespan    (out_makespan),
    .out_finish_time (out_finish_time),
    .out_error       (out_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted schedule state
  logic [31:0] mach_free_at [16];
  logic [31:0] robot_free_at [4];
  logic [3:0]  robot_at [4];
  logic [4:0]  job_ops_done [16];
  logic [3:0]  job_at [16];
  logic [31:0] job_free_at [16];
  logic [31:0] span;
  logic [15:0] travel_dist [256];
  logic [3:0]  alt_mach [1024];
  logic [15:0] alt_dur [1024];
  logic [2:0]  alt_n [256];

  // stimulus-side view of counts and progress, used to steer alternatives
  logic [2:0] gen_alt_n [256];
  logic [4:0] gen_done [16];

  op_item_t pending [$];
  outcome_t span_expected [$];
  op_item_t on_wire;
  outcome_t want;
  int fail_count = 0;
  int items_taken = 0;
  int queued = 0;
  int cycle_count = 0;
  logic steady;

  // a stretch with no idling on either side
  assign steady = (items_taken >= 350) && (items_taken < 500);

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] later_of(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic void clear_plan();
    foreach (mach_free_at[i]) mach_free_at[i] = '0;
    foreach (robot_free_at[i]) begin
      robot_free_at[i] = '0;
      robot_at[i] = '0;
    end
    foreach (job_ops_done[i]) begin
      job_ops_done[i] = '0;
      job_at[i] = '0;
      job_free_at[i] = '0;
    end
    span = '0;
  endfunction

  // schedule evaluation for one accepted item
  function automatic outcome_t evaluate_item(op_item_t it);
    outcome_t r;
    logic [4:0] nop;
    logic [7:0] jo;
    logic [9:0] ai;
    logic [3:0] m;
    logic [3:0] jp;
    logic [31:0] mt;
    logic [31:0] reach;
    logic [31:0] depart;
    logic [31:0] arrive;
    r.finish = '0;
    r.err = 1'b0;
    case (it.kind)
      KIND_LOAD_TRAVEL: travel_dist[{it.from_machine, it.to_machine}] = it.value;
      KIND_LOAD_ALT: begin
        alt_mach[{it.job, it.op_index, it.alt}] = it.from_machine;
        alt_dur[{it.job, it.op_index, it.alt}] = it.value;
        alt_n[{it.job, it.op_index}] = it.alt_count;
      end
      KIND_CLEAR: clear_plan();
      default: begin
        nop = job_ops_done[it.job];
        jo = {it.job, nop[3:0]};
        if (nop >= DEF_MAX_OPS || {1'b0, it.alt} >= alt_n[jo]) begin
          r.err = 1'b1;
        end else begin
          ai = {jo, it.alt};
          m = alt_mach[ai];
          jp = job_at[it.job];
          mt = mach_free_at[m];
          if (m == jp) begin
            mt = add_clamped(mt, 32'(alt_dur[ai]));
          end else begin
            // robot fetches the job, then carries it to the new machine
            reach = add_clamped(robot_free_at[it.robot],
                                32'(travel_dist[{robot_at[it.robot], jp}]));
            depart = later_of(job_free_at[it.job], reach);
            arrive = add_clamped(depart, 32'(travel_dist[{jp, m}]));
            robot_free_at[it.robot] = arrive;
            robot_at[it.robot] = m;
            mt = add_clamped(later_of(mt, arrive), 32'(alt_dur[ai]));
          end
          mach_free_at[m] = mt;
          job_free_at[it.job] = mt;
          job_at[it.job] = m;
          job_ops_done[it.job] = nop + 5'd1;
          span = later_of(span, mt);
          r.finish = mt;
        end
      end
    endcase
    r.makespan = span;
    return r;
  endfunction

  // stimulus helpers
  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  // jobs that the random schedules use, all of their alternatives are loaded
  function automatic int job_of(int k);
    case (k)
      0: return 2;
      1: return 3;
      2: return 12;
      default: return 15;
    endcase
  endfunction

  // machines that alternatives use, travel among them is loaded
  function automatic int mach_of(int k);
    case (k)
      0: return 0;
      1: return 5;
      2: return 10;
      default: return 15;
    endcase
  endfunction

  function automatic int pick_job();
    return job_of($urandom_range(0, 3));
  endfunction

  function automatic int pick_mach();
    return mach_of($urandom_range(0, 3));
  endfunction

  function automatic op_item_t random_item();
    op_item_t it;
    it.kind = kind_t'($urandom_range(0, 3));
    it.job = JOB_W'($urandom_range(0, 15));
    it.op_index = OP_W'($urandom_range(0, 15));
    it.alt = ALT_W'($urandom_range(0, 3));
    it.alt_count = CNT_W'($urandom_range(0, 7));
    it.from_machine = MACH_W'($urandom_range(0, 15));
    it.to_machine = MACH_W'($urandom_range(0, 15));
    it.value = VAL_W'($urandom_range(0, 65535));
    it.robot = ROBOT_W'($urandom_range(0, 3));
    // keep loaded alternatives on loaded machines and schedules on loaded jobs
    if (it.kind == KIND_LOAD_ALT) it.from_machine = MACH_W'(pick_mach());
    if (it.kind == KIND_SCHEDULE) it.job = JOB_W'(pick_job());
    return it;
  endfunction

  function automatic void push_item(op_item_t it);
    logic [4:0] d;
    pending.insert(pending.size(), it);
    queued++;
    case (it.kind)
      KIND_LOAD_ALT: gen_alt_n[{it.job, it.op_index}] = it.alt_count;
      KIND_CLEAR: foreach (gen_done[i]) gen_done[i] = '0;
      KIND_SCHEDULE: begin
        d = gen_done[it.job];
        if (d < DEF_MAX_OPS && {1'b0, it.alt} < gen_alt_n[{it.job, d[3:0]}])
          gen_done[it.job] = d + 5'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic void load_travel(int f, int t, logic [15:0] v);
    op_item_t it;
    it = random_item();
    it.kind = KIND_LOAD_TRAVEL;
    it.from_machine = MACH_W'(f);
    it.to_machine = MACH_W'(t);
    it.value = v;
    push_item(it);
  endfunction

  function automatic void load_alt(int j, int o, int a, int c, int m, logic [15:0] v);
    op_item_t it;
    it = random_item();
    it.kind = KIND_LOAD_ALT;
    it.job = JOB_W'(j);
    it.op_index = OP_W'(o);
    it.alt = ALT_W'(a);
    it.alt_count = CNT_W'(c);
    it.from_machine = MACH_W'(m);
    it.value = v;
    push_item(it);
  endfunction

  function automatic void sched(int j, int a, int rb);
    op_item_t it;
    it = random_item();
    it.kind = KIND_SCHEDULE;
    it.job = JOB_W'(j);
    it.alt = ALT_W'(a);
    it.robot = ROBOT_W'(rb);
    push_item(it);
  endfunction

  function automatic void clear_item();
    op_item_t it;
    it = random_item();
    it.kind = KIND_CLEAR;
    push_item(it);
  endfunction

  // next operation of a job, mostly with a valid alternative
  function automatic void queue_next_op(int j);
    logic [4:0] d;
    int c;
    int a;
    d = gen_done[j];
    c = int'(gen_alt_n[{4'(j), d[3:0]}]);
    if (d < DEF_MAX_OPS && c != 0 && $urandom_range(0, 99) < 85)
      a = $urandom_range(0, ((c > 4) ? 4 : c) - 1);
    else
      a = $urandom_range(0, 3);
    sched(j, a, $urandom_range(0, 3));
  endfunction

  // driver: offers the next pending item, predicts at each transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        span_expected.insert(span_expected.size(), evaluate_item(on_wire));
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          on_wire = pending.pop_front();
          in_kind <= on_wire.kind;
          in_job <= on_wire.job;
          in_op_index <= on_wire.op_index;
          in_alt <= on_wire.alt;
          in_alt_count <= on_wire.alt_count;
          in_from_machine <= on_wire.from_machine;
          in_to_machine <= on_wire.to_machine;
          in_value <= on_wire.value;
          in_robot <= on_wire.robot;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= steady || ($urandom_range(0, 99) >= 25);
      if (out_valid && out_ready) begin
        if (span_expected.size() == 0) begin
          $error("result transfer with no expected result pending");
          fail_count++;
        end else begin
          want = span_expected.pop_front();
          if (out_makespan !== want.makespan) begin
            $error("makespan expected %0d actual %0d", want.makespan, out_makespan);
            fail_count++;
          end
          if (out_finish_time !== want.finish) begin
            $error("finish_time expected %0d actual %0d", want.finish, out_finish_time);
            fail_count++;
          end
          if (out_error !== want.err) begin
            $error("error expected %0d actual %0d", want.err, out_error);
            fail_count++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int base;
    int n_jobs;
    int js [3];
    int c;
    clear_plan();
    foreach (gen_done[i]) gen_done[i] = '0;
    foreach (gen_alt_n[i]) gen_alt_n[i] = '0;

    // fill every entry that a schedule can reach so none is read unwritten
    for (int f = 0; f < 4; f++)
      for (int t = 0; t < 4; t++)
        load_travel(mach_of(f), mach_of(t), pick_time());
    for (int j = 0; j < 4; j++)
      for (int o = 0; o < 16; o++) begin
        c = $urandom_range(1, 4);
        for (int a = 0; a < 4; a++)
          load_alt(job_of(j), o, a, c, pick_mach(), pick_time());
      end

    // directed: extremes, zero count, bad alternative, stay and move
    clear_item();
    load_travel(15, 15, 16'hFFFF);
    load_travel(0, 15, 16'd0);
    load_travel(15, 0, 16'd3);
    load_alt(15, 15, 3, 7, 15, 16'hFFFF);
    load_alt(1, 0, 0, 0, 4, 16'd9);
    sched(1, 0, 0);
    load_alt(2, 0, 0, 1, 0, 16'd7);
    sched(2, 1, 1);
    sched(2, 0, 0);
    load_alt(2, 1, 3, 4, 15, 16'hFFFF);
    sched(2, 3, 3);
    sched(3, 0, 3);
    sched(2, 0, 2);
    clear_item();
    sched(3, 0, 1);
    sched(15, 0, 0);

    // random: mostly clear-then-schedule rounds over a few jobs, some noise
    base = queued;
    while (queued < base + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(random_item());
      end else begin
        if ($urandom_range(0, 4) != 0) clear_item();
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 1) == 0)
            load_travel($urandom_range(0, 15), $urandom_range(0, 15), pick_time());
          else
            load_alt($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 3),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(1, 4),
                     pick_mach(), pick_time());
        end
        n_jobs = $urandom_range(1, 3);
        foreach (js[i]) js[i] = pick_job();
        repeat ($urandom_range(10, 40)) queue_next_op(js[$urandom_range(0, n_jobs - 1)]);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then let the pipeline settle
    while (pending.size() != 0 || in_valid || span_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && span_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== job_shop_transport_makespan_eval_unit.f =====
+incdir+rtl
rtl/jstme_pkg.sv
rtl/jstme_ram.sv
rtl/job_shop_transport_makespan_eval_unit.sv
verif/job_shop_transport_makespan_eval_unit_test.sv
